FILE: design/rtg_pkg.sv
// shared types, mode codes and luma coefficients for the rgb to gray unit
package rtg_pkg;

   // conversion method codes held in the mode register
   typedef enum logic [3:0] {
      MODE_AVG      = 4'd0,
      MODE_BT709    = 4'd1,
      MODE_BT601    = 4'd2,
      MODE_DESAT    = 4'd3,
      MODE_MAX      = 4'd4,
      MODE_MIN      = 4'd5,
      MODE_RED      = 4'd6,
      MODE_GREEN    = 4'd7,
      MODE_BLUE     = 4'd8,
      MODE_SHADE4   = 4'd9,
      MODE_SHADE16  = 4'd10,
      MODE_SHADE32  = 4'd11,
      MODE_SHADE64  = 4'd12
   } mode_type;

   // q16 luma weights, each set sums to 65536
   localparam logic [15:0] BT709_R = 16'd13933;
   localparam logic [15:0] BT709_G = 16'd46871;
   localparam logic [15:0] BT709_B = 16'd4732;
   localparam logic [15:0] BT601_R = 16'd19595;
   localparam logic [15:0] BT601_G = 16'd38470;
   localparam logic [15:0] BT601_B = 16'd7471;

   // floor(x/3) == (x*683)>>11 for x up to 765
   localparam logic [9:0] DIV3_MUL = 10'd683;
   // floor(v/34) == (v*241)>>13 for v up to 527
   localparam logic [7:0] DIV34_MUL = 8'd241;

   // shade steps: 255/(n-1) for 4 and 16 shades, 256/n for 32 and 64 shades
   localparam logic [9:0] STEP4  = 10'd85;
   localparam logic [9:0] STEP16 = 10'd17;
   localparam logic [9:0] STEP32 = 10'd8;
   localparam logic [9:0] STEP64 = 10'd4;

   // per-pixel features passed from the first stage to the second
   typedef struct packed {
      logic [7:0]  avg;
      logic [7:0]  mid;
      logic [7:0]  vmax;
      logic [7:0]  vmin;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [23:0] prod_r;
      logic [23:0] prod_g;
      logic [23:0] prod_b;
   } feat_type;

endpackage

FILE: design/rtg_feat.sv
// first stage: channel average, extremes, mid-point and weighted channel products
module rtg_feat
   import rtg_pkg::*;
(
   input  mode_type   mode,
   input  logic [7:0] red,
   input  logic [7:0] green,
   input  logic [7:0] blue,
   output feat_type   feat
);

   logic [9:0]  sum;
   logic [19:0] avg_prod;
   logic [7:0]  max_rg;
   logic [7:0]  min_rg;
   logic [7:0]  vmax;
   logic [7:0]  vmin;
   logic [8:0]  ext_sum;
   logic [15:0] coef_r;
   logic [15:0] coef_g;
   logic [15:0] coef_b;

   assign sum      = {2'b00, red} + {2'b00, green} + {2'b00, blue};
   // divide by three through the reciprocal
   assign avg_prod = {10'd0, sum} * {10'd0, DIV3_MUL};

   assign max_rg  = (red > green) ? red : green;
   assign min_rg  = (red < green) ? red : green;
   assign vmax    = (max_rg > blue) ? max_rg : blue;
   assign vmin    = (min_rg < blue) ? min_rg : blue;
   assign ext_sum = {1'b0, vmax} + {1'b0, vmin};

   always_comb begin
      unique case (mode)
         MODE_BT709: begin
            coef_r = BT709_R;
            coef_g = BT709_G;
            coef_b = BT709_B;
         end
         default: begin
            coef_r = BT601_R;
            coef_g = BT601_G;
            coef_b = BT601_B;
         end
      endcase
   end

   always_comb begin
      feat.avg    = avg_prod[18:11];
      feat.mid    = ext_sum[8:1];
      feat.vmax   = vmax;
      feat.vmin   = vmin;
      feat.red    = red;
      feat.green  = green;
      feat.blue   = blue;
      feat.prod_r = {16'd0, red}   * {8'd0, coef_r};
      feat.prod_g = {16'd0, green} * {8'd0, coef_g};
      feat.prod_b = {16'd0, blue}  * {8'd0, coef_b};
   end

endmodule

FILE: design/rtg_select.sv
// second stage: luma sum, shade quantizers and method select
module rtg_select
   import rtg_pkg::*;
(
   input  mode_type   mode,
   input  feat_type   feat,
   output logic [7:0] gray
);

   logic [25:0] luma_sum;
   logic [9:0]  luma_hi;
   logic [7:0]  luma;
   logic [9:0]  twice;
   logic [9:0]  v85;
   logic [9:0]  v17;
   logic [9:0]  v8;
   logic [9:0]  v4;
   logic [1:0]  q4;
   logic [17:0] q16_prod;
   logic [3:0]  q16;
   logic [5:0]  q32;
   logic [6:0]  q64;
   logic [8:0]  g32;
   logic [8:0]  g64;
   logic [7:0]  shade4;
   logic [7:0]  shade16;
   logic [7:0]  shade32;
   logic [7:0]  shade64;

   assign luma_sum = {2'b00, feat.prod_r} + {2'b00, feat.prod_g} + {2'b00, feat.prod_b};
   assign luma_hi  = luma_sum[25:16];
   assign luma     = (luma_hi > 10'd255) ? 8'd255 : luma_hi[7:0];

   // round half up: (2a+f) / (2f)
   assign twice = {1'b0, feat.avg, 1'b0};
   assign v85   = twice + STEP4;
   assign v17   = twice + STEP16;
   assign v8    = twice + STEP32;
   assign v4    = twice + STEP64;

   // four shades: quotient by 170 is at most three
   assign q4 = 2'(({1'b0, v85 >= 10'd170}) + ({1'b0, v85 >= 10'd340})
               + ({1'b0, v85 >= 10'd510}));
   assign q16_prod = {8'd0, v17} * {10'd0, DIV34_MUL};
   assign q16      = q16_prod[16:13];
   assign q32      = v8[9:4];
   assign q64      = v4[9:3];

   // q*85 and q*17 repeat the quotient bits
   assign shade4  = {q4, q4, q4, q4};
   assign shade16 = {q16, q16};
   assign g32     = {q32, 3'b000};
   assign g64     = {q64, 2'b00};
   assign shade32 = (g32 > 9'd255) ? 8'd255 : g32[7:0];
   assign shade64 = (g64 > 9'd255) ? 8'd255 : g64[7:0];

   always_comb begin
      unique case (mode)
         MODE_AVG:     gray = feat.avg;
         MODE_BT709:   gray = luma;
         MODE_BT601:   gray = luma;
         MODE_DESAT:   gray = feat.mid;
         MODE_MAX:     gray = feat.vmax;
         MODE_MIN:     gray = feat.vmin;
         MODE_RED:     gray = feat.red;
         MODE_GREEN:   gray = feat.green;
         MODE_BLUE:    gray = feat.blue;
         MODE_SHADE4:  gray = shade4;
         MODE_SHADE16: gray = shade16;
         MODE_SHADE32: gray = shade32;
         MODE_SHADE64: gray = shade64;
         default:      gray = 8'd0;
      endcase
   end

endmodule

FILE: design/rgb_to_gray_multi_mode_unit.sv
// top level of the rgb to gray unit: pixel registers, two compute stages, result register
// a pixel goes through the pixel, feature and result registers to rsp_ (strobe high one cycle)
// throughput: one pixel per clock, set by the three-register pipeline with no feedback
// busy is always low since the receiver cannot stall and no stage ever holds
// reset (synchronous, active high) clears the valid flags and sets mode to plain average
// pixel data registers are not reset
module rgb_to_gray_multi_mode_unit
   import rtg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,
   output logic       rsp_strobe,
   output logic [7:0] rsp_gray
);

   // mode register
   mode_type   mode_ff;
   mode_type   mode_in;

   // pixel input register
   logic       pix_valid_ff;
   logic       pix_valid_in;
   logic [7:0] red_ff;
   logic [7:0] green_ff;
   logic [7:0] blue_ff;

   // feature register between the two compute stages
   logic       feat_valid_ff;
   feat_type   feat_ff;
   feat_type   feat_in;

   // result register
   logic       rsp_strobe_ff;
   logic [7:0] gray_ff;
   logic [7:0] gray_in;

   logic       accept;

   // no stage ever stalls, so a pixel is taken every cycle start is high
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign mode_in      = csr_wr_en ? mode_type'(csr_wr_data) : mode_ff;
   assign pix_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_AVG;
         pix_valid_ff  <= 1'b0;
         feat_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         pix_valid_ff  <= pix_valid_in;
         feat_valid_ff <= pix_valid_ff;
         rsp_strobe_ff <= feat_valid_ff;
      end
   end

   // payload registers, loaded only with live beats
   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
      end
      if (pix_valid_ff) begin
         feat_ff <= feat_in;
      end
      if (feat_valid_ff) begin
         gray_ff <= gray_in;
      end
   end

   // stage one: average, extremes and weighted products
   rtg_feat u_feat (
      .mode  (mode_ff),
      .red   (red_ff),
      .green (green_ff),
      .blue  (blue_ff),
      .feat  (feat_in)
   );

   // stage two: luma, shades and method select
   rtg_select u_select (
      .mode (mode_ff),
      .feat (feat_ff),
      .gray (gray_in)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_gray   = gray_ff;

   // every accepted pixel comes out after the pixel, feature and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("accepted pixel did not produce a result beat");

   // no result beat without a pixel taken before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 3))
      else $error("result beat without a matching pixel");

   // the average and the mid-point always lie between the channel extremes
   a_feat_order: assert property (@(posedge clock) disable iff (reset)
      feat_valid_ff |-> (feat_ff.vmin <= feat_ff.avg) && (feat_ff.avg <= feat_ff.vmax)
                        && (feat_ff.vmin <= feat_ff.mid) && (feat_ff.mid <= feat_ff.vmax))
      else $error("average or mid-point outside the channel range");

endmodule

FILE: tb/tb_rgb_to_gray_multi_mode_unit.sv
// self-checking testbench for the multi-mode rgb to gray unit
`timescale 1ns / 1ps

module tb_rgb_to_gray_multi_mode_unit
   import rtg_pkg::*;
();

   // codes 13 to 15 select no method, the unit must give a gray of zero
   localparam logic [3:0] MODE_SPARE13 = 4'd13;
   localparam logic [3:0] MODE_SPARE14 = 4'd14;
   localparam logic [3:0] MODE_SPARE15 = 4'd15;
   localparam int MODE_CODES = 16;

   localparam int RESET_CYCLES = 9;
   localparam int DRAIN_CYCLES = 6;      // pipeline depth plus margin
   localparam int CYCLE_LIMIT = 60000;
   localparam int IDLE_PERCENT = 27;
   localparam int PHASE_BEATS = 50;

   typedef struct packed {
      logic [3:0] mode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] gray;
   } gray_due_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [7:0] req_red = 8'd0;
   logic [7:0] req_green = 8'd0;
   logic [7:0] req_blue = 8'd0;
   logic       csr_wr_en = 1'b0;
   logic [3:0] csr_wr_data = 4'd0;
   logic       rsp_strobe;
   logic [7:0] rsp_gray;

   gray_due_type gray_due[$];
   logic [3:0]   mode_now = MODE_AVG;
   bit           gaps_on = 1'b1;
   int unsigned  mismatches = 0;
   int unsigned  cycles = 0;

   rgb_to_gray_multi_mode_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_gray    (rsp_gray)
   );

   always #4 clock = ~clock;

   // gray level that one pixel must give under a given mode
   function automatic logic [7:0] predict_gray(input logic [3:0] m,
                                               input logic [7:0] r, g, b);
      int unsigned rr, gg, bb, avg, hi, lo, acc, f, res;
      rr = r;
      gg = g;
      bb = b;
      avg = (rr + gg + bb) / 3;
      hi = (rr > gg) ? rr : gg;
      hi = (hi > bb) ? hi : bb;
      lo = (rr < gg) ? rr : gg;
      lo = (lo < bb) ? lo : bb;
      f = 1;
      case (m)
         MODE_SHADE4:  f = STEP4;
         MODE_SHADE16: f = STEP16;
         MODE_SHADE32: f = STEP32;
         MODE_SHADE64: f = STEP64;
         default:      f = 1;
      endcase
      case (m) inside
         MODE_AVG:   res = avg;
         MODE_BT709: begin
            acc = BT709_R * rr + BT709_G * gg + BT709_B * bb;
            res = acc >> 16;
         end
         MODE_BT601: begin
            acc = BT601_R * rr + BT601_G * gg + BT601_B * bb;
            res = acc >> 16;
         end
         MODE_DESAT: res = (hi + lo) / 2;
         MODE_MAX:   res = hi;
         MODE_MIN:   res = lo;
         MODE_RED:   res = rr;
         MODE_GREEN: res = gg;
         MODE_BLUE:  res = bb;
         // round half up to a multiple of the step
         MODE_SHADE4, MODE_SHADE16, MODE_SHADE32, MODE_SHADE64:
            res = ((2 * avg + f) / (2 * f)) * f;
         default:    res = 0;
      endcase
      if (res > 255)
         res = 255;
      return res[7:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   // offer one pixel, with random idle cycles ahead of it while gaps are on, and book its gray level
   task automatic send_pixel(input logic [7:0] r, g, b);
      gray_due_type due;
      while (gaps_on && $urandom_range(99, 0) < IDLE_PERCENT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      due.mode = mode_now;
      due.red = r;
      due.green = g;
      due.blue = b;
      due.gray = predict_gray(mode_now, r, g, b);
      gray_due.insert(gray_due.size(), due);
   endtask

   task automatic wait_drained();
      while (gray_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mode changes only with the pipeline empty
   task automatic write_mode(input logic [3:0] code);
      start <= 1'b0;
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= code;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_now = code;
   endtask

   function automatic logic [7:0] extreme_byte();
      case ($urandom_range(2, 0))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom_range(255, 0));
      endcase
   endfunction

   // plain average must hold straight out of reset
   task automatic test_reset_default();
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hff, 8'hff, 8'hff);
      send_pixel(8'hc8, 8'h64, 8'h32);
   endtask

   // one or two telling pixels per mode code
   task automatic test_directed_modes();
      write_mode(MODE_AVG);
      send_pixel(8'hff, 8'hff, 8'hfe);
      write_mode(MODE_BT709);
      send_pixel(8'hff, 8'hff, 8'hff);
      send_pixel(8'h0a, 8'hc8, 8'h1e);
      write_mode(MODE_BT601);
      send_pixel(8'hff, 8'hff, 8'hff);
      send_pixel(8'h0a, 8'hc8, 8'h1e);
      write_mode(MODE_DESAT);
      send_pixel(8'hff, 8'h00, 8'h80);
      write_mode(MODE_MAX);
      send_pixel(8'h00, 8'h00, 8'hff);
      write_mode(MODE_MIN);
      send_pixel(8'hff, 8'h01, 8'hff);
      write_mode(MODE_RED);
      send_pixel(8'haa, 8'h55, 8'h11);
      write_mode(MODE_GREEN);
      send_pixel(8'h55, 8'haa, 8'h11);
      write_mode(MODE_BLUE);
      send_pixel(8'h11, 8'h55, 8'haa);
      // half-way points of the coarse shades round up
      write_mode(MODE_SHADE4);
      send_pixel(8'h2b, 8'h2b, 8'h2b);
      send_pixel(8'h2a, 8'h2a, 8'h2a);
      write_mode(MODE_SHADE16);
      send_pixel(8'h09, 8'h09, 8'h09);
      // white overshoots the last level and has to saturate
      write_mode(MODE_SHADE32);
      send_pixel(8'hff, 8'hff, 8'hff);
      write_mode(MODE_SHADE64);
      send_pixel(8'hff, 8'hff, 8'hff);
      write_mode(MODE_SPARE13);
      send_pixel(8'hff, 8'hff, 8'hff);
      write_mode(MODE_SPARE14);
      send_pixel(8'h80, 8'h40, 8'h20);
      write_mode(MODE_SPARE15);
      send_pixel(8'h01, 8'h02, 8'h03);
   endtask

   // every code in a scrambled order, then one more at random
   task automatic test_random_modes();
      logic [7:0] r, g, b, base;
      int unsigned sel;
      for (int k = 0; k <= MODE_CODES; k++) begin
         if (k < MODE_CODES)
            write_mode(4'((k * 5 + 3) % MODE_CODES));
         else
            write_mode(4'($urandom_range(MODE_SPARE15, MODE_AVG)));
         gaps_on = (k != 6);    // one phase runs back to back
         for (int n = 0; n < PHASE_BEATS; n++) begin
            sel = $urandom_range(9, 0);
            if (sel < 6) begin
               r = 8'($urandom_range(255, 0));
               g = 8'($urandom_range(255, 0));
               b = 8'($urandom_range(255, 0));
            end else if (sel < 8) begin
               // near-gray pixels stress the shade boundaries
               base = 8'($urandom_range(255, 0));
               r = base;
               g = base ^ 8'($urandom_range(3, 0));
               b = base ^ 8'($urandom_range(3, 0));
            end else begin
               r = extreme_byte();
               g = extreme_byte();
               b = extreme_byte();
            end
            send_pixel(r, g, b);
         end
      end
      gaps_on = 1'b1;
   endtask

   // every strobed beat is checked against the oldest booked pixel
   always @(posedge clock) begin : check_gray
      gray_due_type due;
      if (!reset && rsp_strobe === 1'b1) begin
         if (gray_due.size() == 0) begin
            report_mismatch($sformatf("gray beat %0d with no pixel pending", rsp_gray));
         end else begin
            due = gray_due.pop_front();
            if (rsp_gray !== due.gray)
               report_mismatch($sformatf("mode %0d rgb %0d/%0d/%0d gray %0d, want %0d",
                                         due.mode, due.red, due.green, due.blue,
                                         rsp_gray, due.gray));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d gray beats pending", gray_due.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_default();
      test_directed_modes();
      test_random_modes();
      start <= 1'b0;
      wait_drained();
      if (gray_due.size() != 0)
         report_mismatch($sformatf("%0d gray beats never came", gray_due.size()));
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
design/rtg_pkg.sv
design/rtg_feat.sv
design/rtg_select.sv
design/rgb_to_gray_multi_mode_unit.sv
tb/tb_rgb_to_gray_multi_mode_unit.sv
